[rtl/dlrs_pkg.sv]
// shared types, constants and functions for the dense layer block
package dlrs_pkg;

   localparam int ValueWidth = 16;
   localparam int AccWidth   = 40;
   localparam int ZWidth     = 32;
   localparam int ExpWidth   = 32;

   localparam logic signed [AccWidth-1:0] AccMax = {1'b0, {(AccWidth-1){1'b1}}};
   localparam logic signed [AccWidth-1:0] AccMin = {1'b1, {(AccWidth-1){1'b0}}};

   localparam logic [30:0] Log2eQ30 = 31'd1549082005;
   localparam logic [19:0] Ln2Q20   = 20'd726817;

   typedef enum logic [1:0] {
      CMD_WEIGHT = 2'd0,
      CMD_BIAS   = 2'd1,
      CMD_ELEM   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_MODE    = 2'd0,
      CSR_INPUTS  = 2'd1,
      CSR_NEURONS = 2'd2,
      CSR_UNUSED  = 2'd3
   } csr_type;

   localparam logic MODE_RELU    = 1'b0;
   localparam logic MODE_SOFTMAX = 1'b1;

   // control handed down the row of accumulator cells
   typedef struct packed {
      logic mac;
      logic clear;
   } cell_ctl_type;

   function automatic logic [20:0] exp2_tab(input logic [3:0] j);
      logic [20:0] v;
      begin
         unique case (j)
            4'd0:  v = 21'd1048576;
            4'd1:  v = 21'd1004120;
            4'd2:  v = 21'd961548;
            4'd3:  v = 21'd920782;
            4'd4:  v = 21'd881744;
            4'd5:  v = 21'd844361;
            4'd6:  v = 21'd808563;
            4'd7:  v = 21'd774282;
            4'd8:  v = 21'd741455;
            4'd9:  v = 21'd710020;
            4'd10: v = 21'd679917;
            4'd11: v = 21'd651091;
            4'd12: v = 21'd623487;
            4'd13: v = 21'd597053;
            4'd14: v = 21'd571740;
            default: v = 21'd547500;
         endcase
         return v;
      end
   endfunction

   function automatic logic signed [AccWidth-1:0] sat40(input logic signed [AccWidth:0] v);
      logic signed [AccWidth-1:0] r;
      begin
         if (v > $signed({AccMax[AccWidth-1], AccMax})) r = AccMax;
         else if (v < $signed({AccMin[AccWidth-1], AccMin})) r = AccMin;
         else r = v[AccWidth-1:0];
         return r;
      end
   endfunction

endpackage

[rtl/dlrs_ram.sv]
// generic simple dual port ram (one write port, one read port) with registered read
module dlrs_ram #(
   parameter int Width = 16,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule

[rtl/dlrs_cell.sv]
// one accumulator cell of the rotating row
module dlrs_cell (
   input  logic                                      clock,
   input  logic                                      reset,
   input  dlrs_pkg::cell_ctl_type                    ctl,
   input  logic signed [dlrs_pkg::AccWidth-1:0]      acc_in,
   input  logic signed [dlrs_pkg::ValueWidth-1:0]    weight,
   input  logic signed [dlrs_pkg::ValueWidth-1:0]    sample,
   output logic signed [dlrs_pkg::AccWidth-1:0]      acc_out
);
   logic signed [dlrs_pkg::AccWidth-1:0] acc_ff, acc_in_nx;
   logic signed [31:0] prod;

   assign prod = weight * sample;

   always_comb begin
      if (ctl.clear) acc_in_nx = '0;
      else if (ctl.mac)
         acc_in_nx = dlrs_pkg::sat40({acc_in[dlrs_pkg::AccWidth-1], acc_in} +
                                     {{(dlrs_pkg::AccWidth-31){prod[31]}}, prod});
      else acc_in_nx = acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) acc_ff <= '0;
      else acc_ff <= acc_in_nx;
   end

   assign acc_out = acc_ff;
endmodule

[rtl/dlrs_exp.sv]
// fixed point e^-d in three registered stages
module dlrs_exp (
   input  logic        clock,
   input  logic        in_valid,
   input  logic [31:0] d,
   output logic        out_valid,
   output logic [31:0] e
);
   logic        v1_ff, v2_ff, v3_ff;
   logic        z1_ff, z2_ff, z3_ff;
   logic [21:0] d1;
   logic [52:0] tfull;
   logic [22:0] t1_ff;
   logic [4:0]  n2_ff, n3_ff;
   logic [3:0]  j2_ff;
   logic [15:0] y2_ff;
   logic [31:0] ymul;
   logic [15:0] y;
   logic [31:0] ysq;
   logic [21:0] p;
   logic [20:0] tab3_ff;
   logic [21:0] p3_ff;
   logic [42:0] mprod;
   logic [32:0] mant;
   logic [32:0] sh;

   assign d1 = d[21:0];
   assign tfull = d1 * dlrs_pkg::Log2eQ30 + 53'd536870912;
   assign ymul = t1_ff[11:0] * dlrs_pkg::Ln2Q20 + 32'd32768;
   assign y = ymul[31:16];
   assign ysq = y2_ff * y2_ff;
   assign p = 22'd1048576 - 22'(y2_ff) + 22'(ysq[31:21]);
   assign mprod = tab3_ff * p3_ff + 43'd512;
   assign mant = mprod[42:10];
   assign sh = mant >> n3_ff;

   always_ff @(posedge clock) begin
      v1_ff <= in_valid;
      v2_ff <= v1_ff;
      v3_ff <= v2_ff;
      z1_ff <= d[31:22] != '0;
      t1_ff <= tfull[52:30];
      z2_ff <= z1_ff || t1_ff[22:16] >= 7'd31;
      n2_ff <= t1_ff[20:16];
      j2_ff <= t1_ff[15:12];
      y2_ff <= y;
      z3_ff <= z2_ff;
      n3_ff <= n2_ff;
      tab3_ff <= dlrs_pkg::exp2_tab(j2_ff);
      p3_ff <= p;
   end

   assign out_valid = v3_ff;
   assign e = z3_ff ? 32'd0 : sh[31:0];
endmodule

[rtl/dense_layer_relu_softmax.sv]
// dense layer with relu or softmax output over a rotating row of accumulator cells
//  channel | dir | handshake           | payload
//  req     | in  | req_tvalid/tready   | tdata cmd,elem_index,neuron_sel,value; tlast
//  rsp     | out | rsp_tvalid/tready   | tdata out_neuron,out_value; tlast; tuser size_error
//  csr     | in  | csr_valid/ready     | csr_index, csr_data
// a weight or bias write is taken while idle; an element rotates the row of accumulators
// past the single weight port, one cell per step, then returns to idle.
// the last element then adds the bias and clears the row; relu sends each result through
// the output register, softmax runs exp over all neurons and a 48-step division per result;
// a stalled result holds the output and blocks new requests.
// reset clears accumulators and element count, and sets mode relu, 1024 inputs, 16 neurons.
module dense_layer_relu_softmax #(
   parameter int MAX_INPUTS  = 1024,
   parameter int MAX_NEURONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // cmd, elem_index, neuron_sel, value
   input  logic        req_tlast,   // last_elem
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_neuron, out_value
   output logic        rsp_tlast,   // out_last
   output logic        rsp_tuser,   // size_error
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);
   localparam int NW  = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
   localparam int IW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam int WD  = MAX_INPUTS * MAX_NEURONS;
   localparam int WAW = $clog2(WD);
   localparam int CW  = $clog2(MAX_NEURONS + 1);
   localparam int ACW = dlrs_pkg::AccWidth;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b00000001,
      ST_MAC  = 8'b00000010,
      ST_BIAS = 8'b00000100,
      ST_MAX  = 8'b00001000,
      ST_EXP  = 8'b00010000,
      ST_DIV  = 8'b00100000,
      ST_OUT  = 8'b01000000,
      ST_WAIT = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   // config
   logic        mode_ff;
   logic [10:0] icount_ff;
   logic [4:0]  ncount_ff;
   logic [10:0] seen_ff;

   // request fields
   logic [1:0]  r_cmd;
   logic [9:0]  r_idx;
   logic [3:0]  r_sel;
   logic signed [15:0] r_val;
   assign r_cmd = req_tdata[1:0];
   assign r_idx = req_tdata[11:2];
   assign r_sel = req_tdata[15:12];
   assign r_val = req_tdata[31:16];

   logic acc_req;
   assign acc_req = req_tvalid && req_tready;

   // weight memory
   logic           w_we;
   logic [WAW-1:0] w_waddr, w_raddr;
   logic [15:0]    w_rdata;
   logic           idx_ok, sel_ok;
   assign idx_ok = 32'(r_idx) < MAX_INPUTS;
   assign sel_ok = 32'(r_sel) < MAX_NEURONS;
   assign w_we = acc_req && dlrs_pkg::cmd_type'(r_cmd) == dlrs_pkg::CMD_WEIGHT && idx_ok && sel_ok;
   assign w_waddr = WAW'(32'(r_idx) * MAX_NEURONS + 32'(r_sel));

   dlrs_ram #(.Width(16), .Depth(WD)) u_wram (
      .clock(clock), .wr_en(w_we), .wr_addr(w_waddr), .wr_data(r_val),
      .rd_addr(w_raddr), .rd_data(w_rdata));

   logic signed [15:0] bias_ff [MAX_NEURONS];

   // element sequencing
   logic [IW-1:0]      eidx_ff;
   logic               eok_ff;
   logic signed [15:0] samp_ff;
   logic               elast_ff;
   logic [CW-1:0]      step_ff;
   logic               rd_ok_ff;
   assign w_raddr = WAW'(32'(eidx_ff) * MAX_NEURONS + 32'(step_ff[NW-1:0]));

   // row of cells rotating toward index 0, last cell sees the multiplier
   logic signed [ACW-1:0] acc [MAX_NEURONS];
   logic signed [ACW-1:0] accin [MAX_NEURONS];
   dlrs_pkg::cell_ctl_type cctl;
   logic rot;
   logic signed [15:0] wsel;
   assign wsel = rd_ok_ff ? w_rdata : 16'sd0;

   generate
      for (genvar g = 0; g < MAX_NEURONS; g++) begin : g_cell
         dlrs_pkg::cell_ctl_type c;
         always_comb begin
            c.clear = cctl.clear;
            c.mac = cctl.mac && (g == MAX_NEURONS - 1);
         end
         assign accin[g] = rot ? acc[(g + 1) % MAX_NEURONS] : acc[g];
         dlrs_cell u_cell (
            .clock(clock), .reset(reset), .ctl(c), .acc_in(accin[g]),
            .weight(wsel), .sample(samp_ff), .acc_out(acc[g]));
      end
   endgenerate

   // finish stage
   logic [CW-1:0]  nc;
   logic [CW-1:0]  k_ff;
   logic signed [31:0] z_ff [MAX_NEURONS];
   logic [31:0]    ev_ff [MAX_NEURONS];
   logic signed [31:0] m_ff;
   logic [36:0]    sum_ff;
   logic           err_ff;

   always_comb begin
      if (ncount_ff == 5'd0) nc = CW'(1);
      else if (32'(ncount_ff) > MAX_NEURONS) nc = CW'(MAX_NEURONS);
      else nc = CW'(ncount_ff);
   end

   logic signed [ACW-1:0] biased;
   logic signed [ACW:0]   bsum;
   assign bsum = {acc[0][ACW-1], acc[0]} +
                 {{(ACW-27){bias_ff[k_ff[NW-1:0]][15]}}, bias_ff[k_ff[NW-1:0]], 12'd0};
   assign biased = dlrs_pkg::sat40(bsum);

   // exp unit
   logic        ex_go, ex_ov;
   logic [31:0] ex_d, ex_e;
   logic [CW-1:0] ex_wk_ff;
   dlrs_exp u_exp (.clock(clock), .in_valid(ex_go), .d(ex_d), .out_valid(ex_ov), .e(ex_e));

   // restoring divider: q = (e << 16) / sum
   logic [5:0]  dcnt_ff;
   logic [47:0] num_ff;
   logic [37:0] rem_ff;
   logic [47:0] quo_ff;
   logic [37:0] rem_sh;
   assign rem_sh = {rem_ff[36:0], num_ff[47]};

   // output register
   logic        ov_ff;
   logic [3:0]  on_ff;
   logic [31:0] oval_ff;
   logic        olast_ff;
   logic        oerr_ff;

   assign req_tready = state_ff == ST_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = {4'd0, oval_ff, on_ff};
   assign rsp_tlast = olast_ff;
   assign rsp_tuser = oerr_ff;

   always_comb begin
      cctl = '{mac: 1'b0, clear: 1'b0};
      rot = 1'b0;
      ex_go = 1'b0;
      ex_d = 32'(m_ff - z_ff[k_ff[NW-1:0]]);
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (acc_req && dlrs_pkg::cmd_type'(r_cmd) == dlrs_pkg::CMD_ELEM)
            state_in = ST_MAC;
         ST_MAC: begin
            if (step_ff != '0) begin
               cctl.mac = 1'b1;
               rot = 1'b1;
            end
            if (32'(step_ff) == MAX_NEURONS)
               state_in = elast_ff ? ST_BIAS : ST_IDLE;
         end
         ST_BIAS: begin
            rot = 1'b1;
            if (32'(k_ff) == MAX_NEURONS - 1) state_in = ST_MAX;
         end
         ST_MAX: begin
            cctl.clear = 1'b1;
            state_in = (mode_ff == dlrs_pkg::MODE_SOFTMAX) ? ST_EXP : ST_OUT;
         end
         ST_EXP: begin
            ex_go = k_ff < nc;
            if (ex_wk_ff == nc) state_in = ST_DIV;
         end
         ST_DIV: if (dcnt_ff == 6'd49) state_in = ST_OUT;
         ST_OUT: if (!ov_ff || rsp_tready) state_in = ST_WAIT;
         ST_WAIT: if (!ov_ff || rsp_tready)
            state_in = (k_ff == nc) ? ST_IDLE :
                       (mode_ff == dlrs_pkg::MODE_SOFTMAX ? ST_DIV : ST_OUT);
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff <= dlrs_pkg::MODE_RELU;
         icount_ff <= 11'd1024;
         ncount_ff <= 5'd16;
         seen_ff <= '0;
         ov_ff <= 1'b0;
         step_ff <= '0;
         k_ff <= '0;
         ex_wk_ff <= '0;
         dcnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            unique case (dlrs_pkg::csr_type'(csr_index))
               dlrs_pkg::CSR_MODE:    mode_ff <= csr_data[0];
               dlrs_pkg::CSR_INPUTS:  icount_ff <= csr_data;
               dlrs_pkg::CSR_NEURONS: ncount_ff <= csr_data[4:0];
               default: ;
            endcase
         end
         if (ov_ff && rsp_tready) ov_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               step_ff <= '0;
               k_ff <= '0;
               if (acc_req && dlrs_pkg::cmd_type'(r_cmd) == dlrs_pkg::CMD_ELEM &&
                   seen_ff != 11'd2047)
                  seen_ff <= seen_ff + 11'd1;
            end
            ST_MAC: begin
               step_ff <= step_ff + CW'(1);
               if (32'(step_ff) == MAX_NEURONS) err_ff <= seen_ff != icount_ff;
            end
            ST_BIAS: k_ff <= k_ff + CW'(1);
            ST_MAX: begin
               k_ff <= '0;
               ex_wk_ff <= '0;
               seen_ff <= '0;
               sum_ff <= '0;
            end
            ST_EXP: begin
               if (ex_wk_ff == nc) k_ff <= '0;
               else if (k_ff < nc) k_ff <= k_ff + CW'(1);
               if (ex_ov) begin
                  ev_ff[ex_wk_ff[NW-1:0]] <= ex_e;
                  sum_ff <= sum_ff + 37'(ex_e);
                  ex_wk_ff <= ex_wk_ff + CW'(1);
               end
            end
            ST_DIV: begin
               if (dcnt_ff == '0) begin
                  num_ff <= {ev_ff[k_ff[NW-1:0]], 16'd0};
                  rem_ff <= '0;
                  quo_ff <= '0;
                  dcnt_ff <= dcnt_ff + 6'd1;
               end else if (dcnt_ff == 6'd49) begin
                  dcnt_ff <= '0;
               end else begin
                  num_ff <= num_ff << 1;
                  if (rem_sh >= {1'b0, sum_ff}) begin
                     rem_ff <= rem_sh - {1'b0, sum_ff};
                     quo_ff <= {quo_ff[46:0], 1'b1};
                  end else begin
                     rem_ff <= rem_sh;
                     quo_ff <= {quo_ff[46:0], 1'b0};
                  end
                  dcnt_ff <= dcnt_ff + 6'd1;
               end
            end
            ST_OUT: if (!ov_ff || rsp_tready) begin
               ov_ff <= 1'b1;
               on_ff <= 4'(k_ff);
               olast_ff <= k_ff + CW'(1) == nc;
               oerr_ff <= err_ff;
               if (mode_ff == dlrs_pkg::MODE_SOFTMAX) oval_ff <= quo_ff[31:0];
               else oval_ff <= z_ff[k_ff[NW-1:0]][31] ? 32'd0 : z_ff[k_ff[NW-1:0]];
               k_ff <= k_ff + CW'(1);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (acc_req && dlrs_pkg::cmd_type'(r_cmd) == dlrs_pkg::CMD_BIAS && sel_ok)
         bias_ff[NW'(r_sel)] <= r_val;
      if (state_ff == ST_IDLE) begin
         eidx_ff <= IW'(r_idx);
         eok_ff <= idx_ok;
         samp_ff <= r_val;
         elast_ff <= req_tlast;
      end
      rd_ok_ff <= eok_ff;
      if (state_ff == ST_BIAS) begin
         z_ff[k_ff[NW-1:0]] <= 32'(biased >>> 8);
         if (k_ff == '0 || ($signed(biased >>> 8) > m_ff && k_ff < nc))
            m_ff <= 32'(biased >>> 8);
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped under stall");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while results pending");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MAX |=> seen_ff == '0)
      else $error("element count not cleared");
endmodule
